// ===== src/pal_pkg.sv =====
// Shared types and constants for the positional array list.
package pal_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int CMD_W            = 3;
   localparam int VAL_W            = 32;
   localparam int POS_W            = 7;
   localparam int CNT_OUT_W        = 7;
   localparam int STATUS_W         = 2;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_READ      = 3'd0,
      CMD_APPEND    = 3'd1,
      CMD_INSERT    = 3'd2,
      CMD_UPDATE    = 3'd3,
      CMD_POP       = 3'd4,
      CMD_REMOVE_AT = 3'd5
   } cmd_type;

   // Status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic signed [VAL_W-1:0] value;
      logic [POS_W-1:0]        position;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic [CNT_OUT_W-1:0]    count;
      logic [STATUS_W-1:0]     status;
   } rsp_type;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_READ,
      OP_APPEND,
      OP_UPDATE,
      OP_POP,
      OP_INS_START,
      OP_INS_STEP,
      OP_INS_DONE,
      OP_REM_START,
      OP_REM_STEP
   } dp_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_INS_SHIFT,
      ST_INS_FIN,
      ST_REM_SHIFT,
      ST_REM_FIN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic      load;
      logic      latch_status;
      logic      result;
      dp_op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    ok;
      logic    shift_needed;
      logic    shift_last;
      logic    rsp_free;
   } dp_status_type;

endpackage

// ===== src/positional_array_list.sv =====
// Positional array list: ordered list of signed 32-bit values with a count.
//
// A request transaction (req_valid/req_ready, req_payload) carries a command:
// read, append, insert at position, update, remove last or remove at position.
// Each one yields exactly one response transaction (rsp_valid/rsp_ready,
// rsp_payload) with the value read, the count afterwards and a status.
// One request is worked on at a time; req_ready is high while the controller
// is idle, also while an earlier response still waits in the output register.
// The command is loaded, checked in the execute step and, if it is valid and
// no entries have to move, carried out there; the result step then fills the
// output register that drives rsp_valid. Insert and remove at position p first
// move the entries behind p one place up or down, then finish before the
// result step. The move runs one entry per cycle through the single read and
// single write port of the element RAM. The next request can be accepted in
// the same cycle in which rsp_valid rises.
// A stalled receiver holds the response; the block finishes the next command
// and waits in its result step until the output register is free.
// Reset clears the count and all handshake state; the element RAM is not
// cleared, since only entries below the count are ever read.
module positional_array_list #(
   parameter int CAPACITY = pal_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pal_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pal_pkg::rsp_type rsp_payload
);

   pal_pkg::ctrl_cmd_type  cmd;
   pal_pkg::dp_status_type status;

   pal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pal_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== src/pal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pal_ctrl.sv =====
// Controller state machine for the positional array list.
module pal_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pal_pkg::dp_status_type status,
   output pal_pkg::ctrl_cmd_type  cmd
);

   pal_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pal_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pal_pkg::ST_IDLE: begin
            if (req_valid) state_in = pal_pkg::ST_EXEC;
         end
         pal_pkg::ST_EXEC: begin
            state_in = pal_pkg::ST_RESULT;
            if (status.ok && status.shift_needed) begin
               if (status.cmd == pal_pkg::CMD_INSERT) state_in = pal_pkg::ST_INS_SHIFT;
               if (status.cmd == pal_pkg::CMD_REMOVE_AT) state_in = pal_pkg::ST_REM_SHIFT;
            end
         end
         pal_pkg::ST_INS_SHIFT: begin
            if (status.shift_last) state_in = pal_pkg::ST_INS_FIN;
         end
         pal_pkg::ST_REM_SHIFT: begin
            if (status.shift_last) state_in = pal_pkg::ST_REM_FIN;
         end
         pal_pkg::ST_INS_FIN: state_in = pal_pkg::ST_RESULT;
         pal_pkg::ST_REM_FIN: state_in = pal_pkg::ST_RESULT;
         pal_pkg::ST_RESULT: begin
            if (status.rsp_free) state_in = pal_pkg::ST_IDLE;
         end
         default: state_in = pal_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready        = 1'b0;
      cmd.load         = 1'b0;
      cmd.latch_status = 1'b0;
      cmd.result       = 1'b0;
      cmd.op           = pal_pkg::OP_NONE;
      unique case (state_ff)
         pal_pkg::ST_IDLE: begin
            // no transaction is taken while reset is held
            req_ready = !reset;
            cmd.load  = req_valid && !reset;
         end
         pal_pkg::ST_EXEC: begin
            cmd.latch_status = 1'b1;
            if (status.ok) begin
               case (status.cmd)
                  pal_pkg::CMD_READ:   cmd.op = pal_pkg::OP_READ;
                  pal_pkg::CMD_APPEND: cmd.op = pal_pkg::OP_APPEND;
                  pal_pkg::CMD_UPDATE: cmd.op = pal_pkg::OP_UPDATE;
                  pal_pkg::CMD_POP:    cmd.op = pal_pkg::OP_POP;
                  pal_pkg::CMD_INSERT: begin
                     cmd.op = status.shift_needed ? pal_pkg::OP_INS_START
                                                  : pal_pkg::OP_INS_DONE;
                  end
                  pal_pkg::CMD_REMOVE_AT: begin
                     cmd.op = status.shift_needed ? pal_pkg::OP_REM_START
                                                  : pal_pkg::OP_POP;
                  end
                  default: cmd.op = pal_pkg::OP_NONE;
               endcase
            end
         end
         pal_pkg::ST_INS_SHIFT: cmd.op = pal_pkg::OP_INS_STEP;
         pal_pkg::ST_REM_SHIFT: cmd.op = pal_pkg::OP_REM_STEP;
         pal_pkg::ST_INS_FIN:   cmd.op = pal_pkg::OP_INS_DONE;
         pal_pkg::ST_REM_FIN:   cmd.op = pal_pkg::OP_POP;
         pal_pkg::ST_RESULT:    cmd.result = status.rsp_free;
         default: cmd.op = pal_pkg::OP_NONE;
      endcase
   end

endmodule

// ===== src/pal_datapath.sv =====
// Datapath: request register, count, shift pointer, element store and result register.
module pal_datapath #(
   parameter int CAPACITY = pal_pkg::CAPACITY_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pal_pkg::req_type       req_payload,
   input  pal_pkg::ctrl_cmd_type  cmd,
   output pal_pkg::dp_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pal_pkg::rsp_type       rsp_payload
);

   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int EW  = ((CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W) + 1;

   pal_pkg::req_type               req_ff;
   logic [CW-1:0]                  count_ff, count_in;
   logic [AW-1:0]                  ptr_ff, ptr_in;
   logic [pal_pkg::STATUS_W-1:0]   status_ff;
   pal_pkg::rsp_type               rsp_ff;
   logic                           rsp_valid_ff;

   logic [EW-1:0]                  pos_e, cnt_e, ptr_e;
   logic                           full, empty;
   pal_pkg::cmd_type               cur_cmd;
   logic [pal_pkg::STATUS_W-1:0]   code;

   logic                           wr_en, rd_en;
   logic [AW-1:0]                  wr_addr, rd_addr;
   logic [pal_pkg::VAL_W-1:0]      wr_data, rd_data;

   assign cur_cmd = pal_pkg::cmd_type'(req_ff.command);
   assign pos_e   = EW'(req_ff.position);
   assign cnt_e   = EW'(count_ff);
   assign ptr_e   = EW'(ptr_ff);
   assign full    = (count_ff == CW'(CAPACITY));
   assign empty   = (count_ff == '0);

   // Range, full and empty checks of the held transaction
   always_comb begin
      case (cur_cmd)
         pal_pkg::CMD_READ, pal_pkg::CMD_UPDATE:
            code = (pos_e < cnt_e) ? pal_pkg::STATUS_OK : pal_pkg::STATUS_RANGE;
         pal_pkg::CMD_APPEND:
            code = full ? pal_pkg::STATUS_FULL : pal_pkg::STATUS_OK;
         pal_pkg::CMD_INSERT:
            code = (pos_e > cnt_e) ? pal_pkg::STATUS_RANGE
                 : (full ? pal_pkg::STATUS_FULL : pal_pkg::STATUS_OK);
         pal_pkg::CMD_POP:
            code = empty ? pal_pkg::STATUS_EMPTY : pal_pkg::STATUS_OK;
         pal_pkg::CMD_REMOVE_AT:
            code = empty ? pal_pkg::STATUS_EMPTY
                 : ((pos_e >= cnt_e) ? pal_pkg::STATUS_RANGE : pal_pkg::STATUS_OK);
         default: code = pal_pkg::STATUS_OK;
      endcase
   end

   // Status toward the controller
   always_comb begin
      status.cmd      = cur_cmd;
      status.ok       = (code == pal_pkg::STATUS_OK);
      status.rsp_free = !rsp_valid_ff || rsp_ready;
      if (cur_cmd == pal_pkg::CMD_INSERT) begin
         status.shift_needed = (pos_e < cnt_e);
         status.shift_last   = (ptr_e == pos_e + EW'(1));
      end else begin
         status.shift_needed = (pos_e + EW'(1) < cnt_e);
         status.shift_last   = (ptr_e + EW'(2) == cnt_e);
      end
   end

   // Store access, count and pointer updates per operation
   always_comb begin
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      wr_addr  = AW'(req_ff.position);
      rd_addr  = AW'(req_ff.position);
      wr_data  = req_ff.value;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      unique case (cmd.op)
         pal_pkg::OP_NONE: ;
         pal_pkg::OP_READ: rd_en = 1'b1;
         pal_pkg::OP_APPEND: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(count_ff);
            count_in = count_ff + CW'(1);
         end
         pal_pkg::OP_UPDATE: wr_en = 1'b1;
         pal_pkg::OP_POP: count_in = count_ff - CW'(1);
         pal_pkg::OP_INS_START: begin
            rd_en   = 1'b1;
            rd_addr = AW'(cnt_e - EW'(1));
            ptr_in  = AW'(count_ff);
         end
         pal_pkg::OP_INS_STEP: begin
            // move the entry read last cycle up one place, fetch the next one down
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = rd_data;
            rd_en   = !status.shift_last;
            rd_addr = AW'(ptr_e - EW'(2));
            ptr_in  = AW'(ptr_e - EW'(1));
         end
         pal_pkg::OP_INS_DONE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end
         pal_pkg::OP_REM_START: begin
            rd_en   = 1'b1;
            rd_addr = AW'(pos_e + EW'(1));
            ptr_in  = AW'(req_ff.position);
         end
         pal_pkg::OP_REM_STEP: begin
            // move the entry read last cycle down one place, fetch the next one up
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = rd_data;
            rd_en   = !status.shift_last;
            rd_addr = AW'(ptr_e + EW'(2));
            ptr_in  = AW'(ptr_e + EW'(1));
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.load) begin
         req_ff <= req_payload;
      end
      if (cmd.latch_status) begin
         status_ff <= code;
      end
      if (cmd.result) begin
         rsp_ff.read_value <= (cur_cmd == pal_pkg::CMD_READ && status_ff == pal_pkg::STATUS_OK)
                              ? rd_data : '0;
         rsp_ff.count      <= pal_pkg::CNT_OUT_W'(count_ff);
         rsp_ff.status     <= status_ff;
      end
   end

   pal_ram #(
      .WIDTH (pal_pkg::VAL_W),
      .DEPTH (CAPACITY)
   ) u_elements (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== tb/sv/positional_array_list_tb.sv =====
// Testbench for the positional array list: random and directed commands, checked by a scoreboard.
`timescale 1ns / 1ps

module positional_array_list_tb;
   import pal_pkg::*;

   localparam int          LIST_DEPTH  = CAPACITY_DEFAULT;
   localparam int          PHASE_ITEMS = 420;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int          SETTLE_CYCLES = 2 * (LIST_DEPTH + 5);

   // command codes the block leaves unused
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   // command mix of the random part
   typedef enum int {MIX_GROW, MIX_SHRINK} mix_type;

   // Scoreboard: shadow list plus the queue of replies still owed
   class array_list_tracker;
      logic signed [VAL_W-1:0] shadow_elems [LIST_DEPTH];
      int unsigned             shadow_count;
      rsp_type                 pending_replies [$];
      int                      errors;

      function new();
         shadow_count = 0;
         errors       = 0;
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction

      // apply one accepted command to the shadow list, queue its reply
      function void note_command(req_type cmd_item);
         rsp_type     reply;
         int unsigned pos;
         reply = '0;
         pos   = cmd_item.position;
         case (cmd_item.command)
            CMD_READ: begin
               if (pos < shadow_count) reply.read_value = shadow_elems[pos];
               else reply.status = STATUS_RANGE;
            end
            CMD_APPEND: begin
               if (shadow_count >= LIST_DEPTH) begin
                  reply.status = STATUS_FULL;
               end else begin
                  shadow_elems[shadow_count] = cmd_item.value;
                  shadow_count++;
               end
            end
            CMD_INSERT: begin
               // range test wins over the full test
               if (pos > shadow_count) begin
                  reply.status = STATUS_RANGE;
               end else if (shadow_count >= LIST_DEPTH) begin
                  reply.status = STATUS_FULL;
               end else begin
                  for (int i = shadow_count; i > pos; i--)
                     shadow_elems[i] = shadow_elems[i-1];
                  shadow_elems[pos] = cmd_item.value;
                  shadow_count++;
               end
            end
            CMD_UPDATE: begin
               if (pos < shadow_count) shadow_elems[pos] = cmd_item.value;
               else reply.status = STATUS_RANGE;
            end
            CMD_POP: begin
               if (shadow_count == 0) reply.status = STATUS_EMPTY;
               else shadow_count--;
            end
            CMD_REMOVE_AT: begin
               if (shadow_count == 0) begin
                  reply.status = STATUS_EMPTY;
               end else if (pos >= shadow_count) begin
                  reply.status = STATUS_RANGE;
               end else begin
                  for (int i = pos; i + 1 < shadow_count; i++)
                     shadow_elems[i] = shadow_elems[i+1];
                  shadow_count--;
               end
            end
            default: begin
               // spare codes: no effect
            end
         endcase
         reply.count = CNT_OUT_W'(shadow_count);
         pending_replies.push_back(reply);
      endfunction

      // compare one accepted response with the oldest queued reply
      function void check_reply(rsp_type got);
         rsp_type want;
         if (pending_replies.size() == 0) begin
            $error("response with none queued: read_value %0d count %0d status %0d",
                   got.read_value, got.count, got.status);
            errors++;
            return;
         end
         want = pending_replies.pop_front();
         if (got.read_value !== want.read_value) begin
            $error("read_value expected %0d actual %0d", want.read_value, got.read_value);
            errors++;
         end
         if (got.count !== want.count) begin
            $error("count expected %0d actual %0d", want.count, got.count);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   array_list_tracker tracker;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_cycles   = 0;
   int unsigned cycle_count   = 0;

   positional_array_list u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   // run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("positional_array_list: mismatch");
         $finish;
      end
   end

   function automatic req_type make_req(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val,
                                        logic [POS_W-1:0] pos);
      req_type r;
      r.command  = cmd;
      r.value    = val;
      r.position = pos;
      return r;
   endfunction

   // offer one command transaction, optionally after an idle gap
   task automatic drive_command(req_type cmd_item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= cmd_item;
      do @(posedge clock); while (!req_ready);
      tracker.note_command(cmd_item);
   endtask

   // stop offering until every queued reply has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(39))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return '0;
         3:       return -1;
         default: return $urandom;
      endcase
   endfunction

   // random command, weighted toward filling or emptying the list
   function automatic req_type pick_command(mix_type mix);
      int unsigned      n;
      int unsigned      roll;
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] pos;
      n    = tracker.shadow_count;
      roll = $urandom_range(99);
      if (mix == MIX_GROW) begin
         if      (roll < 45) cmd = CMD_APPEND;
         else if (roll < 75) cmd = CMD_INSERT;
         else if (roll < 85) cmd = CMD_READ;
         else if (roll < 93) cmd = CMD_UPDATE;
         else if (roll < 96) cmd = CMD_POP;
         else if (roll < 98) cmd = CMD_REMOVE_AT;
         else cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      end else begin
         if      (roll < 35) cmd = CMD_POP;
         else if (roll < 65) cmd = CMD_REMOVE_AT;
         else if (roll < 80) cmd = CMD_READ;
         else if (roll < 90) cmd = CMD_UPDATE;
         else if (roll < 95) cmd = CMD_APPEND;
         else if (roll < 98) cmd = CMD_INSERT;
         else cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      end
      // mostly in-range positions, some anywhere in the field
      if ($urandom_range(9) == 0) pos = POS_W'($urandom_range(127));
      else if (cmd == CMD_INSERT) pos = POS_W'($urandom_range(n, 0));
      else if (n == 0) pos = '0;
      else pos = POS_W'($urandom_range(n - 1, 0));
      return make_req(cmd, pick_value(), pos);
   endfunction

   task automatic run_random(int items);
      int      real_items;
      mix_type mix;
      req_type r;
      real_items = 0;
      mix        = MIX_GROW;
      while (real_items < items) begin
         if (tracker.shadow_count == 0) mix = MIX_GROW;
         else if (tracker.shadow_count >= LIST_DEPTH && $urandom_range(5) == 0) mix = MIX_SHRINK;
         r = pick_command(mix);
         if (r.command != CMD_SPARE_LO && r.command != CMD_SPARE_HI) real_items++;
         drive_command(r);
      end
   endtask

   // response side: check accepted transactions, stall at random or on request
   initial begin
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) tracker.check_reply(rsp_payload);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list corners, extremes, every command
      drive_command(make_req(CMD_READ,      '0,      7'd0));
      drive_command(make_req(CMD_UPDATE,    VAL_MAX, 7'd0));
      drive_command(make_req(CMD_POP,       '0,      7'd0));
      drive_command(make_req(CMD_REMOVE_AT, '0,      7'd0));
      drive_command(make_req(CMD_INSERT,    VAL_MIN, 7'd1));
      drive_command(make_req(CMD_INSERT,    VAL_MIN, 7'd0));
      drive_command(make_req(CMD_APPEND,    VAL_MAX, 7'd127));
      drive_command(make_req(CMD_APPEND,    -1,      7'd0));
      drive_command(make_req(CMD_INSERT,    32'sh5555_5555, 7'd3));
      drive_command(make_req(CMD_INSERT,    32'shAAAA_AAAA, 7'd0));
      drive_command(make_req(CMD_INSERT,    '0,      7'd6));
      drive_command(make_req(CMD_READ,      '0,      7'd0));
      drive_command(make_req(CMD_READ,      '0,      7'd4));
      drive_command(make_req(CMD_READ,      '0,      7'd5));
      drive_command(make_req(CMD_READ,      '0,      7'd127));
      drive_command(make_req(CMD_UPDATE,    32'sd1,  7'd2));
      drive_command(make_req(CMD_UPDATE,    32'sd1,  7'd64));
      drive_command(make_req(CMD_READ,      '0,      7'd2));
      drive_command(make_req(CMD_REMOVE_AT, '0,      7'd0));
      drive_command(make_req(CMD_REMOVE_AT, '0,      7'd4));
      drive_command(make_req(CMD_REMOVE_AT, '0,      7'd127));
      drive_command(make_req(CMD_SPARE_LO,  VAL_MAX, 7'd127));
      drive_command(make_req(CMD_SPARE_HI,  VAL_MIN, 7'd0));
      drive_command(make_req(CMD_POP,       '0,      7'd0));
      drive_command(make_req(CMD_READ,      '0,      7'd0));

      // sender sparse, receiver mostly stalled; a long receiver hold-off midway
      send_idle_pct = 38;
      recv_idle_pct = 81;
      run_random(PHASE_ITEMS / 2);
      hold_cycles = 400;
      run_random(PHASE_ITEMS / 2);
      wait_drained();

      // roles swapped
      send_idle_pct = 81;
      recv_idle_pct = 38;
      run_random(PHASE_ITEMS);

      // back to back on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(PHASE_ITEMS);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("positional_array_list: match");
      end else begin
         $display("positional_array_list: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/pal_pkg.sv
src/pal_ram.sv
src/pal_ctrl.sv
src/pal_datapath.sv
src/positional_array_list.sv
tb/sv/positional_array_list_tb.sv
